/* rtl/perlin_noise_octaves_core_macros.svh */
// Assertion macros shared by the noise core RTL.
`ifndef PERLIN_NOISE_OCTAVES_CORE_MACROS_SVH
`define PERLIN_NOISE_OCTAVES_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define PNO_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define PNO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pno_pkg.sv */
// Shared constants and types for the octave noise core.
package pno_pkg;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int PERM_SIZE       = 256;
	localparam int IDX_W           = $clog2(PERM_SIZE);

	localparam int COORD_W     = 32;
	localparam int BASE_FREQ_W = 24;
	localparam int OCT_CNT_W   = 4;
	localparam int PERSIST_W   = 16;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int NOISE_W     = 16;
	localparam int AMP_W       = 32;
	localparam int FRAC_W      = 16;
	localparam int SCALE_W     = 24;
	localparam int PSCALE_W    = 40;
	localparam int FADE_W      = 20;
	localparam int VAL_W       = 21;

	localparam logic [BASE_FREQ_W-1:0] BASE_FREQ_RST = 24'd65536;
	localparam logic [OCT_CNT_W-1:0]   OCT_CNT_RST   = 4'd1;
	localparam logic [PERSIST_W-1:0]   PERSIST_RST   = 16'd16384;
	localparam logic [AMP_W-1:0]       AMP_START     = 32'd13107;

	localparam logic CMD_EVAL = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_FREQ = 2'd0,
		REG_OCT_COUNT = 2'd1,
		REG_PERSIST   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             first;
		logic             last;
		logic             none;
		logic [AMP_W-1:0] amp;
	} oct_meta_t;

endpackage

/* rtl/perlin_noise_octaves_core.sv */
// Octave-summed 3D gradient noise core: sequencer, octave pipeline, divider.
// Usage:
//  - Input channel (in_valid/in_ready) takes one item per handshake: cmd selects
//    evaluate (point in coord_x/y/z, signed Q16.16) or load (one table entry).
//  - Output channel (out_valid/out_ready) returns noise_value, Q0.16, one per
//    evaluate item; a load returns nothing.
//  - Config writes (cfg_we, cfg_index, cfg_data) are registered; write only
//    while idle. Indices past the last register are ignored.
//  - An evaluate item issues one octave per cycle into the octave pipeline
//    unless the output stalls, N = min(octave_count, MAX_OCTAVES) octaves or
//    one empty octave when N is zero, and the next item is taken as the last
//    octave issues. The octave sequencer sets that rate.
//  - Results pass nine octave stages, one accumulate stage, a 17-stage divider
//    and the output register. A load waits until the sequencer is idle and no
//    octave is in the table lookup stages S1 to S3.
//  - When the receiver stalls, the output register holds and every stage
//    freezes; nothing is dropped or repeated.
//  - Reset clears config to defaults, empties the pipeline and marks the
//    permutation table as identity at once.
`include "perlin_noise_octaves_core_macros.svh"

module perlin_noise_octaves_core #(
	parameter int MAX_OCTAVES = pno_pkg::MAX_OCTAVES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [pno_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pno_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   cmd,
	input  logic signed [pno_pkg::COORD_W-1:0]     coord_x,
	input  logic signed [pno_pkg::COORD_W-1:0]     coord_y,
	input  logic signed [pno_pkg::COORD_W-1:0]     coord_z,
	input  logic [pno_pkg::IDX_W-1:0]              table_index,
	input  logic [pno_pkg::IDX_W-1:0]              table_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pno_pkg::NOISE_W-1:0]            noise_value
);
	import pno_pkg::*;

	localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
	localparam int PROD_W = VAL_W + AMP_W + 1;
	localparam int TOT_W  = PROD_W + OCT_W;
	localparam int SUM_W  = AMP_W + OCT_W;
	localparam int RW     = TOT_W - 1;
	localparam int NPORT  = 14;
	localparam int NCOPY  = NPORT / 2;
	localparam int DSTG   = NOISE_W;
	localparam int GRAD_W = FRAC_W + 2;
	localparam int MUL_W  = COORD_W + BASE_FREQ_W + 1;
	localparam int SH_W   = 6;
	localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(1 << FRAC_W);

	// 16-way gradient select
	function automatic logic signed [VAL_W-1:0] grad(input logic [3:0] h,
			input logic signed [GRAD_W-1:0] x, input logic signed [GRAD_W-1:0] y,
			input logic signed [GRAD_W-1:0] z);
		logic signed [GRAD_W-1:0] a;
		logic signed [GRAD_W-1:0] b;
		logic signed [VAL_W-1:0]  ae;
		logic signed [VAL_W-1:0]  be;
		a = (h < 4'd8) ? x : y;
		if (h < 4'd4) begin
			b = y;
		end else if (h inside {4'd12, 4'd14}) begin
			b = x;
		end else begin
			b = z;
		end
		ae = VAL_W'(a);
		be = VAL_W'(b);
		return (h[0] ? -ae : ae) + (h[1] ? -be : be);
	endfunction

	// a + floor(t * (b - a) / 2^16)
	function automatic logic signed [VAL_W-1:0] lerp(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input logic [FADE_W-1:0] t);
		logic signed [VAL_W:0]              d;
		logic signed [VAL_W+FADE_W+1:0]     p;
		d = (VAL_W+1)'(b) - (VAL_W+1)'(a);
		p = $signed({1'b0, t}) * d;
		return a + VAL_W'(p >>> FRAC_W);
	endfunction

	// configuration
	logic [BASE_FREQ_W-1:0] base_freq_q;
	logic [OCT_CNT_W-1:0]   oct_cnt_q;
	logic [PERSIST_W-1:0]   persist_q;

	// handshake and sequencer
	logic                    adv;
	logic                    tbl_busy;
	logic                    eval_acc;
	logic                    load_acc;
	logic                    issue_last;
	logic                    seq_busy_q;
	logic [OCT_W-1:0]        seq_k_q;
	logic [OCT_W-1:0]        seq_cnt_q;
	logic [OCT_W-1:0]        cnt_d;
	logic [AMP_W-1:0]        seq_amp_q;
	logic [AMP_W-1:0]        amp_next;
	logic [AMP_W+PERSIST_W-1:0] amp_mul;
	logic [PSCALE_W-1:0]     p_q [3];
	logic signed [MUL_W-1:0] mul [3];
	logic [SCALE_W-1:0]      sc [3];

	// octave pipeline
	logic                    vld_s  [1:9];
	oct_meta_t               meta_s [1:9];
	logic [IDX_W-1:0]        xi_s1, yi_s1, zi_s1, yi_s2, zi_s2, zi_s3;
	logic [FRAC_W-1:0]       f_s1 [3];
	logic [FRAC_W-1:0]       f_s2 [3];
	logic [FRAC_W-1:0]       f_s3 [3];
	logic [FRAC_W-1:0]       f_s4 [3];
	logic [2*FRAC_W-1:0]     tt_s2 [3];
	logic [FRAC_W-1:0]       t3_s3 [3];
	logic [FADE_W-1:0]       q_s3 [3];
	logic [FADE_W-1:0]       fd_s4 [3];
	logic [FADE_W-1:0]       fd_s5 [3];
	logic [FADE_W-1:0]       fd_s6 [3];
	logic [FADE_W-1:0]       fd_s7 [3];
	logic signed [VAL_W-1:0] g_s5 [8];
	logic signed [VAL_W-1:0] l_s6 [4];
	logic signed [VAL_W-1:0] y_s7 [2];
	logic signed [VAL_W-1:0] m_s8;
	logic signed [PROD_W-1:0] prod_s9;

	// permutation table read ports
	logic [PERM_SIZE-1:0]    perm_vld_q;
	logic [IDX_W-1:0]        pr_addr [NPORT];
	logic [IDX_W-1:0]        pr_rd   [NPORT];
	logic                    pr_vld_q [NPORT];
	logic [IDX_W-1:0]        pr_idx_q [NPORT];
	logic [IDX_W-1:0]        pr_val  [NPORT];

	// accumulator and divider
	logic                    acc_done_q;
	logic signed [TOT_W-1:0] acc_total_q;
	logic [SUM_W-1:0]        acc_sum_q;
	logic                    dv_vld_s  [0:DSTG];
	logic                    dv_zero_s [0:DSTG];
	logic                    dv_sat_s  [0:DSTG];
	logic [RW-1:0]           dv_rem_s  [0:DSTG];
	logic [SUM_W-1:0]        dv_sum_s  [0:DSTG];
	logic [NOISE_W-1:0]      dv_q_s    [0:DSTG];

	logic                    out_valid_q;
	logic [NOISE_W-1:0]      noise_q;

	// advance everything unless the output register is full and stalled
	assign adv = !out_valid_q || out_ready;

	// accept control
	always_comb begin
		issue_last = seq_busy_q && ((seq_cnt_q == '0) || (seq_k_q == seq_cnt_q - 1'b1));
		tbl_busy   = seq_busy_q || vld_s[1] || vld_s[2] || vld_s[3];
		if (cmd == CMD_LOAD) begin
			in_ready = adv && !tbl_busy;
		end else begin
			in_ready = adv && (!seq_busy_q || issue_last);
		end
		eval_acc = in_valid && in_ready && (cmd == CMD_EVAL);
		load_acc = in_valid && in_ready && (cmd == CMD_LOAD);
		if (32'(oct_cnt_q) > MAX_OCTAVES) begin
			cnt_d = OCT_W'(MAX_OCTAVES);
		end else begin
			cnt_d = OCT_W'(oct_cnt_q);
		end
	end

	// scale point by base frequency once per item; amplitude step per octave
	always_comb begin
		mul[0] = $signed(coord_x) * $signed({1'b0, base_freq_q});
		mul[1] = $signed(coord_y) * $signed({1'b0, base_freq_q});
		mul[2] = $signed(coord_z) * $signed({1'b0, base_freq_q});
		amp_mul = seq_amp_q * persist_q;
		if (|amp_mul[AMP_W+PERSIST_W-1:AMP_W+14]) begin
			amp_next = '1;
		end else begin
			amp_next = amp_mul[AMP_W+13:14];
		end
		for (int a = 0; a < 3; a++) begin
			sc[a] = SCALE_W'(p_q[a] >> (SH_W'(FRAC_W) - SH_W'(seq_k_q)));
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_freq_q <= BASE_FREQ_RST;
			oct_cnt_q   <= OCT_CNT_RST;
			persist_q   <= PERSIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_FREQ: base_freq_q <= cfg_data[BASE_FREQ_W-1:0];
				REG_OCT_COUNT: oct_cnt_q   <= cfg_data[OCT_CNT_W-1:0];
				REG_PERSIST:   persist_q   <= cfg_data[PERSIST_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_busy_q  <= 1'b0;
			seq_k_q     <= '0;
			seq_cnt_q   <= '0;
			for (int i = 1; i <= 9; i++) begin
				vld_s[i] <= 1'b0;
			end
			acc_done_q  <= 1'b0;
			for (int i = 0; i <= DSTG; i++) begin
				dv_vld_s[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (eval_acc) begin
				seq_busy_q <= 1'b1;
				seq_k_q    <= '0;
				seq_cnt_q  <= cnt_d;
			end else if (issue_last) begin
				seq_busy_q <= 1'b0;
			end else if (seq_busy_q) begin
				seq_k_q <= seq_k_q + 1'b1;
			end
			vld_s[1] <= seq_busy_q;
			for (int i = 2; i <= 9; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			acc_done_q  <= vld_s[9] && meta_s[9].last;
			dv_vld_s[0] <= acc_done_q;
			for (int i = 1; i <= DSTG; i++) begin
				dv_vld_s[i] <= dv_vld_s[i-1];
			end
			out_valid_q <= dv_vld_s[DSTG];
		end
	end

	// table valid bits: an entry never loaded reads as its own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_vld_q <= '0;
		end else if (load_acc) begin
			perm_vld_q[table_index] <= 1'b1;
		end
	end

	// table copies, two read ports each, all written together
	for (genvar c = 0; c < NCOPY; c++) begin : g_copy
		logic [IDX_W-1:0] mem [PERM_SIZE];
		logic [IDX_W-1:0] rd0_q;
		logic [IDX_W-1:0] rd1_q;
		always_ff @(posedge clk) begin
			if (load_acc) begin
				mem[table_index] <= table_value;
			end
			if (adv) begin
				rd0_q <= mem[pr_addr[2*c]];
				rd1_q <= mem[pr_addr[2*c+1]];
			end
		end
		assign pr_rd[2*c]   = rd0_q;
		assign pr_rd[2*c+1] = rd1_q;
	end

	// resolve reads and form the next hash addresses
	always_comb begin
		for (int i = 0; i < NPORT; i++) begin
			pr_val[i] = pr_vld_q[i] ? pr_rd[i] : pr_idx_q[i];
		end
		pr_addr[0] = xi_s1;
		pr_addr[1] = xi_s1 + 1'b1;
		for (int j = 0; j < 2; j++) begin
			for (int k = 0; k < 2; k++) begin
				pr_addr[2 + 2*j + k] = pr_val[j] + yi_s2 + IDX_W'(k);
			end
		end
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 2; k++) begin
				pr_addr[6 + 2*j + k] = pr_val[2 + j] + zi_s3 + IDX_W'(k);
			end
		end
	end

	// octave datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			// hold the item's scaled coordinates and amplitude
			if (eval_acc) begin
				seq_amp_q <= AMP_START;
				for (int a = 0; a < 3; a++) begin
					p_q[a] <= PSCALE_W'(mul[a]);
				end
			end else if (seq_busy_q) begin
				seq_amp_q <= amp_next;
			end

			// S1: lattice cell and fraction
			meta_s[1].first <= (seq_k_q == '0);
			meta_s[1].last  <= issue_last;
			meta_s[1].none  <= (seq_cnt_q == '0);
			meta_s[1].amp   <= seq_amp_q;
			xi_s1 <= sc[0][SCALE_W-1:FRAC_W];
			yi_s1 <= sc[1][SCALE_W-1:FRAC_W];
			zi_s1 <= sc[2][SCALE_W-1:FRAC_W];
			for (int a = 0; a < 3; a++) begin
				f_s1[a] <= sc[a][FRAC_W-1:0];
			end
			for (int i = 2; i <= 9; i++) begin
				meta_s[i] <= meta_s[i-1];
			end

			// table reads
			for (int i = 0; i < NPORT; i++) begin
				pr_vld_q[i] <= perm_vld_q[pr_addr[i]];
				pr_idx_q[i] <= pr_addr[i];
			end

			// S2..S4: carry lattice bits, fade polynomial
			yi_s2 <= yi_s1;
			zi_s2 <= zi_s1;
			zi_s3 <= zi_s2;
			for (int a = 0; a < 3; a++) begin
				f_s2[a]  <= f_s1[a];
				f_s3[a]  <= f_s2[a];
				f_s4[a]  <= f_s3[a];
				tt_s2[a] <= 32'(f_s1[a]) * 32'(f_s1[a]);
				t3_s3[a] <= FRAC_W'((32'(tt_s2[a][2*FRAC_W-1:FRAC_W]) * 32'(f_s2[a]))
					>> FRAC_W);
				q_s3[a]  <= FADE_W'(((37'(tt_s2[a]) * 37'(6)) + (37'(10) << 32)
					- ((37'(f_s2[a]) * 37'(15)) << FRAC_W)) >> FRAC_W);
				fd_s4[a] <= FADE_W'((36'(t3_s3[a]) * 36'(q_s3[a])) >> FRAC_W);
				fd_s5[a] <= fd_s4[a];
				fd_s6[a] <= fd_s5[a];
				fd_s7[a] <= fd_s6[a];
			end

			// S5: corner gradients, corner index is 4x + 2y + z
			for (int c = 0; c < 8; c++) begin
				g_s5[c] <= grad(pr_val[6 + c][3:0],
					(c >= 4) ? {2'b11, f_s4[0]} : {2'b00, f_s4[0]},
					((c % 4) >= 2) ? {2'b11, f_s4[1]} : {2'b00, f_s4[1]},
					((c % 2) == 1) ? {2'b11, f_s4[2]} : {2'b00, f_s4[2]});
			end

			// S6..S8: trilinear blend, map to (n + 1) / 2
			for (int j = 0; j < 4; j++) begin
				l_s6[j] <= lerp(g_s5[2*(j%2) + j/2], g_s5[4 + 2*(j%2) + j/2], fd_s5[0]);
			end
			y_s7[0] <= lerp(l_s6[0], l_s6[1], fd_s6[1]);
			y_s7[1] <= lerp(l_s6[2], l_s6[3], fd_s6[1]);
			m_s8    <= (lerp(y_s7[0], y_s7[1], fd_s7[2]) + ONE_Q) >>> 1;

			// S9: weight by amplitude
			prod_s9 <= m_s8 * $signed({1'b0, meta_s[8].amp});

			// accumulate octaves of one item
			if (vld_s[9]) begin
				acc_total_q <= (meta_s[9].first ? TOT_W'(0) : acc_total_q)
					+ (meta_s[9].none ? TOT_W'(0) : TOT_W'(prod_s9));
				acc_sum_q   <= (meta_s[9].first ? SUM_W'(0) : acc_sum_q)
					+ (meta_s[9].none ? SUM_W'(0) : SUM_W'(meta_s[9].amp));
			end

			// divider: flags, then one quotient bit per stage
			dv_zero_s[0] <= acc_total_q[TOT_W-1] || (acc_total_q == '0);
			dv_sat_s[0]  <= RW'(acc_total_q) >= (RW'(acc_sum_q) << NOISE_W);
			dv_rem_s[0]  <= RW'(acc_total_q);
			dv_sum_s[0]  <= acc_sum_q;
			dv_q_s[0]    <= '0;
			for (int i = 0; i < DSTG; i++) begin
				dv_zero_s[i+1] <= dv_zero_s[i];
				dv_sat_s[i+1]  <= dv_sat_s[i];
				dv_sum_s[i+1]  <= dv_sum_s[i];
				if (dv_rem_s[i] >= (RW'(dv_sum_s[i]) << (DSTG - 1 - i))) begin
					dv_rem_s[i+1] <= dv_rem_s[i] - (RW'(dv_sum_s[i]) << (DSTG - 1 - i));
					dv_q_s[i+1]   <= dv_q_s[i] | (NOISE_W'(1) << (DSTG - 1 - i));
				end else begin
					dv_rem_s[i+1] <= dv_rem_s[i];
					dv_q_s[i+1]   <= dv_q_s[i];
				end
			end

			// output register with saturation
			if (dv_zero_s[DSTG]) begin
				noise_q <= '0;
			end else if (dv_sat_s[DSTG]) begin
				noise_q <= '1;
			end else begin
				noise_q <= dv_q_s[DSTG];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;

	`PNO_ASSERT_SAME(a_load_tbl_idle, load_acc,
		!seq_busy_q && !vld_s[1] && !vld_s[2] && !vld_s[3],
		"table load overlaps an item in lookup")
	`PNO_ASSERT_SAME(a_oct_in_range, seq_busy_q && (seq_cnt_q != '0),
		seq_k_q < seq_cnt_q, "octave index past count")
	`PNO_ASSERT_SAME(a_empty_sum, acc_done_q && (acc_sum_q == '0),
		acc_total_q == '0, "nonzero total with zero amplitude sum")
	`PNO_ASSERT_NEXT(a_stall_hold, !adv,
		$stable(seq_k_q) && $stable(dv_vld_s[DSTG]), "pipeline moved during stall")

endmodule

/* tb/perlin_noise_octaves_core_test.sv */
// Self-checking testbench for the octave-summed 3D gradient noise core.
module perlin_noise_octaves_core_test;
	import pno_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 48;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic [IDX_W-1:0] table_index;
	logic [IDX_W-1:0] table_value;
	logic out_valid;
	logic out_ready;
	logic [NOISE_W-1:0] noise_value;

	// predictor state
	logic [BASE_FREQ_W-1:0] freq_shadow;
	logic [OCT_CNT_W-1:0] octaves_shadow;
	logic [PERSIST_W-1:0] persist_shadow;
	logic [7:0] perm_shadow [PERM_SIZE];
	logic [NOISE_W-1:0] pending_noise [$];

	int send_idle_pct;
	int recv_stall_pct;
	int recv_hold_cycles;
	int mismatch_count;
	int cycle_count;

	perlin_noise_octaves_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.table_index(table_index), .table_value(table_value),
		.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Check each result against the oldest prediction, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_noise.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected noise item %0d", noise_value);
			end else begin
				if (noise_value !== pending_noise[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("noise mismatch: expected %0d, got %0d",
							pending_noise[0], noise_value);
				end
				void'(pending_noise.pop_front());
			end
		end
		if (recv_hold_cycles > 0) begin
			out_ready <= 1'b0;
			recv_hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [23:0] scaled_coord(logic signed [31:0] c, int k);
		longint prod;
		logic [63:0] bits;
		prod = longint'(c) * longint'({1'b0, freq_shadow});
		bits = prod;
		bits = bits << k;
		return bits[39:16];
	endfunction

	function automatic longint fade_curve(longint f);
		longint unsigned t, t2, t3, q;
		t = f;
		t2 = (t * t) >> 16;
		t3 = (t2 * t) >> 16;
		q = (64'd6 * t * t + (64'd10 << 32) - ((64'd15 * t) << 16)) >> 16;
		return longint'((t3 * q) >> 16);
	endfunction

	function automatic longint gradient_dot(int h, longint x, longint y, longint z);
		longint a, b;
		h = h & 15;
		a = (h < 8) ? x : y;
		if (h < 4)
			b = y;
		else if (h == 12 || h == 14)
			b = x;
		else
			b = z;
		return ((h & 1) ? -a : a) + ((h & 2) ? -b : b);
	endfunction

	function automatic longint blend(longint a, longint b, longint u);
		return a + ((u * (b - a)) >>> 16);
	endfunction

	function automatic int corner_hash(int x, int y, int z);
		int a, b;
		a = int'(perm_shadow[x & 255]);
		b = int'(perm_shadow[(a + y) & 255]);
		return int'(perm_shadow[(b + z) & 255]);
	endfunction

	function automatic longint octave_level(logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] cz, int k);
		logic [23:0] sx, sy, sz;
		int xi, yi, zi;
		longint xf, yf, zf, xg, yg, zg, u, v, w, x1, x2, y1, y2, n;
		sx = scaled_coord(cx, k);
		sy = scaled_coord(cy, k);
		sz = scaled_coord(cz, k);
		xi = int'(sx[23:16]);
		yi = int'(sy[23:16]);
		zi = int'(sz[23:16]);
		xf = longint'(sx[15:0]);
		yf = longint'(sy[15:0]);
		zf = longint'(sz[15:0]);
		xg = xf - 65536;
		yg = yf - 65536;
		zg = zf - 65536;
		u = fade_curve(xf);
		v = fade_curve(yf);
		w = fade_curve(zf);
		x1 = blend(gradient_dot(corner_hash(xi, yi, zi), xf, yf, zf),
			gradient_dot(corner_hash(xi + 1, yi, zi), xg, yf, zf), u);
		x2 = blend(gradient_dot(corner_hash(xi, yi + 1, zi), xf, yg, zf),
			gradient_dot(corner_hash(xi + 1, yi + 1, zi), xg, yg, zf), u);
		y1 = blend(x1, x2, v);
		x1 = blend(gradient_dot(corner_hash(xi, yi, zi + 1), xf, yf, zg),
			gradient_dot(corner_hash(xi + 1, yi, zi + 1), xg, yf, zg), u);
		x2 = blend(gradient_dot(corner_hash(xi, yi + 1, zi + 1), xf, yg, zg),
			gradient_dot(corner_hash(xi + 1, yi + 1, zi + 1), xg, yg, zg), u);
		y2 = blend(x1, x2, v);
		n = blend(y1, y2, w);
		return (n + 65536) >>> 1;
	endfunction

	function automatic logic [NOISE_W-1:0] noise_of_point(logic signed [31:0] cx,
			logic signed [31:0] cy, logic signed [31:0] cz);
		longint total, quot;
		longint unsigned amp, amp_sum;
		int count;
		total = 0;
		amp = 64'(AMP_START);
		amp_sum = 0;
		count = (octaves_shadow > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : int'(octaves_shadow);
		for (int k = 0; k < count; k++) begin
			total += octave_level(cx, cy, cz, k) * longint'(amp);
			amp_sum += amp;
			amp = (amp * persist_shadow) >> 14;
			if (amp > 64'hFFFF_FFFF)
				amp = 64'hFFFF_FFFF;
		end
		if (amp_sum == 0 || total <= 0)
			return '0;
		quot = total / longint'(amp_sum);
		return (quot > 65535) ? 16'hFFFF : quot[15:0];
	endfunction

	// Offer one item after a random gap; predict it once accepted
	task automatic send_item(logic c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [7:0] idx, logic [7:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		table_index <= idx;
		table_value <= val;
		do
			@(posedge clk);
		while (!in_ready);
		if (c == CMD_LOAD)
			perm_shadow[idx] = val;
		else
			pending_noise.push_back(noise_of_point(x, y, z));
	endtask

	task automatic send_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_item(CMD_EVAL, x, y, z, 8'($urandom), 8'($urandom));
	endtask

	// Drop valid and hold until every result is back and the core settles
	task automatic drain_all();
		in_valid <= 1'b0;
		while (pending_noise.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BASE_FREQ: freq_shadow = data;
			REG_OCT_COUNT: octaves_shadow = data[OCT_CNT_W-1:0];
			REG_PERSIST:   persist_shadow = data[PERSIST_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [23:0] freq, logic [3:0] octs, logic [15:0] pers);
		write_reg(REG_BASE_FREQ, freq);
		write_reg(REG_OCT_COUNT, CFG_DATA_W'(octs));
		write_reg(REG_PERSIST, CFG_DATA_W'(pers));
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
			2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
		endcase
	endfunction

	task automatic send_random(int load_pct);
		if ($urandom_range(99) < load_pct)
			send_item(CMD_LOAD, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
		else
			send_eval(random_coord(), random_coord(), random_coord());
	endtask

	// Extreme points and table loads at reset defaults
	task automatic test_directed_points();
		send_eval(0, 0, 0);
		send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_eval(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000);
		send_eval(32'h0001_8000, 32'hFFFE_4000, 32'h00FF_C000);
		send_item(CMD_LOAD, 0, 0, 0, 8'd0, 8'd255);
		send_item(CMD_LOAD, 0, 0, 0, 8'd255, 8'd0);
		send_item(CMD_LOAD, 0, 0, 0, 8'd1, 8'd77);
		send_eval(32'h0000_4000, 32'h0000_C000, 32'h0000_2000);
		send_eval(32'h00FF_8000, 32'hFF00_8000, 32'h0000_8000);
		drain_all();
	endtask

	// Corner settings of the registers, including an ignored index
	task automatic test_register_extremes();
		set_config(24'd0, 4'd3, 16'd16384);
		send_eval(32'h1234_5678, 32'h8765_4321, 32'h0001_0000);
		drain_all();
		set_config(24'hFF_FFFF, 4'd8, 16'hFFFF);
		send_eval(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF);
		send_eval(32'h0000_1234, 32'hFFFF_EDCB, 32'h0003_0000);
		drain_all();
		set_config(24'h01_0000, 4'd0, 16'd0);
		send_eval(32'h0002_8000, 32'h0001_0000, 32'h0000_0001);
		drain_all();
		set_config(24'h00_8000, 4'd15, 16'd0);
		send_eval(32'h0005_5555, 32'hFFFA_AAAB, 32'h0000_FFFF);
		drain_all();
		write_reg(REG_UNUSED, 24'hFF_FFFF);
		set_config(24'h03_0000, 4'd5, 16'h8000);
		send_eval(32'h0001_1111, 32'h0002_2222, 32'h0003_3333);
		send_eval(32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0000);
		drain_all();
	endtask

	// Random items under one idling mode per phase, fresh settings per phase
	task automatic test_random_traffic();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			if (phase == 7)
				set_config(24'hFF_FFFF, 4'd15, 16'hFFFF);
			else
				set_config($urandom_range(1) ? 24'($urandom) : 24'($urandom_range(24'h04_0000)),
					4'($urandom_range(15)), 16'($urandom));
			repeat (120) send_random(12);
			drain_all();
		end
	endtask

	// Long receiver hold while the sender keeps offering, then random receiver stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(24'h01_8000, 4'd2, 16'd12000);
		recv_hold_cycles = 400;
		repeat (60) send_random(10);
		drain_all();
		recv_stall_pct = 40;
		repeat (40) send_random(10);
		drain_all();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_EVAL;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		table_index = '0;
		table_value = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold_cycles = 0;
		mismatch_count = 0;
		cycle_count = 0;
		freq_shadow = BASE_FREQ_RST;
		octaves_shadow = OCT_CNT_RST;
		persist_shadow = PERSIST_RST;
		for (int i = 0; i < PERM_SIZE; i++)
			perm_shadow[i] = 8'(i);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_points();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();
		drain_all();
		if (mismatch_count == 0 && pending_noise.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
